### rtl/assert_macros.svh
// assertion macros used by the accumulator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLKD(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
	else $error("assertion failed");
`else
`define ASSERT_CLKD(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

### rtl/pca_pkg.sv
// shared constants of the photon count accumulator
package pca_pkg;
	localparam int PIXELS_DEF = 65536;
	localparam int IDX_W = 16;
	localparam int VAL_W = 32;
	localparam int ACC_W = 32;
	localparam int STEP_W = 31;
	localparam int PIX_W = 17;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_W = 40;
	localparam int MEAN_W = 24;
	localparam int PH_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXELS = 2'd2;

	localparam logic [VAL_W-1:0] THRESHOLD_RST = 32'd0;
	localparam logic [STEP_W-1:0] STEP_RST = 31'd65536;
	localparam logic [PIX_W-1:0] PIXELS_RST = 17'd65536;
endpackage

### rtl/pca_ram.sv
// generic single-write single-read ram with registered read
module pca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/photon_count_accumulator.sv
// photon count accumulator: threshold discretizer with per-pixel accumulation
// after reset a clearing pass zeroes the accumulator ram, with in_ready low
// sample item: ram read, photon division, update, a mean division when it closes a frame, then finish
// readout item: ram read, average division, finish; no division when no frame was seen or the index is out of range
// one item in flight; the shared 40-step restoring divider sets the item rate
// arst_n clears control state, frame total and frame counter and loads the config register defaults
`include "assert_macros.svh"

module photon_count_accumulator #(
	parameter int PIXELS = pca_pkg::PIXELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pca_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pca_pkg::VAL_W-1:0]       cfg_data,
	// input items
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            kind,
	input  logic [pca_pkg::IDX_W-1:0]       pixel_index,
	input  logic signed [pca_pkg::VAL_W-1:0] pixel_value,
	input  logic                            last_of_frame,
	// result items
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pca_pkg::PH_W-1:0]        pixel_photons,
	output logic                            frame_done,
	output logic [pca_pkg::ACC_W-1:0]       frame_total,
	output logic [pca_pkg::MEAN_W-1:0]      frame_mean,
	output logic [pca_pkg::DIV_W-1:0]       average_count
);
	localparam int AW = PIXELS > 1 ? $clog2(PIXELS) : 1;
	localparam int DW = pca_pkg::DIV_W;
	localparam int CW = $clog2(DW + 1);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_READ  = 8'b0000_0100,
		ST_DIVP  = 8'b0000_1000,
		ST_UPD   = 8'b0001_0000,
		ST_DIVM  = 8'b0010_0000,
		ST_DIVA  = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic signed [pca_pkg::VAL_W-1:0] thr_q;
	logic [pca_pkg::STEP_W-1:0]       step_q;
	logic [pca_pkg::PIX_W-1:0]        pix_q;

	// running state
	logic [pca_pkg::ACC_W-1:0] run_total_q;
	logic [pca_pkg::ACC_W-1:0] frames_q;
	logic [AW-1:0]             clr_q;

	// captured item
	logic                             kind_q;
	logic [pca_pkg::IDX_W-1:0]        idx_q;
	logic signed [pca_pkg::VAL_W-1:0] val_q;
	logic                             last_q;
	logic [pca_pkg::ACC_W-1:0]        acc_q;

	// pending result
	logic [pca_pkg::PH_W-1:0]   res_ph_q;
	logic                       res_done_q;
	logic [pca_pkg::ACC_W-1:0]  res_total_q;
	logic [pca_pkg::MEAN_W-1:0] res_mean_q;
	logic [DW-1:0]              res_avg_q;

	// shared divider: numerator register collects quotient bits
	logic [DW-1:0]              div_num_q;
	logic [pca_pkg::ACC_W:0]    div_rem_q;
	logic [pca_pkg::ACC_W-1:0]  div_den_q;
	logic [CW-1:0]              div_cnt_q;
	logic [pca_pkg::ACC_W:0]    rem_sh;
	logic                       q_bit;
	logic                       div_busy;

	// ram port signals
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [pca_pkg::ACC_W-1:0] ram_wdata;
	logic [pca_pkg::ACC_W-1:0] ram_rdata;

	// datapath helpers
	logic                           in_range;
	logic signed [pca_pkg::VAL_W:0] diff;
	logic [pca_pkg::STEP_W-1:0]     step_eff;
	logic [pca_pkg::PIX_W-1:0]      pix_eff;
	logic [DW-1:0]                  ph_num;
	logic [pca_pkg::ACC_W:0]        ph;
	logic [pca_pkg::ACC_W+1:0]      acc_sum;
	logic [pca_pkg::ACC_W+1:0]      tot_sum;
	logic [pca_pkg::ACC_W-1:0]      acc_new;
	logic [pca_pkg::ACC_W-1:0]      tot_new;
	logic                           in_xfer;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;

	assign in_range = 32'(idx_q) < PIXELS;
	assign step_eff = (step_q == '0) ? pca_pkg::STEP_W'(1) : step_q;
	assign pix_eff  = (pix_q == '0) ? pca_pkg::PIX_W'(1) : pix_q;
	assign diff     = {val_q[pca_pkg::VAL_W-1], val_q} - {thr_q[pca_pkg::VAL_W-1], thr_q};
	// ceil division by adding step minus one; below threshold gives zero
	assign ph_num   = diff[pca_pkg::VAL_W] ? '0 :
		DW'(diff[pca_pkg::VAL_W-1:0]) + DW'(step_eff) - DW'(1);

	assign ph      = div_num_q[pca_pkg::ACC_W:0];
	assign acc_sum = (pca_pkg::ACC_W+2)'(acc_q) + (pca_pkg::ACC_W+2)'(ph);
	assign tot_sum = (pca_pkg::ACC_W+2)'(run_total_q) + (pca_pkg::ACC_W+2)'(ph);
	assign acc_new = (acc_sum[pca_pkg::ACC_W+1:pca_pkg::ACC_W] != 2'b00) ? '1 :
		acc_sum[pca_pkg::ACC_W-1:0];
	assign tot_new = (tot_sum[pca_pkg::ACC_W+1:pca_pkg::ACC_W] != 2'b00) ? '1 :
		tot_sum[pca_pkg::ACC_W-1:0];

	// one restoring step per cycle
	assign rem_sh   = {div_rem_q[pca_pkg::ACC_W-1:0], div_num_q[DW-1]};
	assign q_bit    = rem_sh >= {1'b0, div_den_q};
	assign div_busy = div_cnt_q != '0;

	// ram writes: clearing pass or accumulator update of an in-range pixel
	assign ram_we    = (state_q == ST_CLEAR) || ((state_q == ST_UPD) && in_range);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : AW'(idx_q);
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : acc_new;

	pca_ram #(
		.WIDTH(pca_pkg::ACC_W),
		.DEPTH(PIXELS)
	) u_acc_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(AW'(pixel_index)),
		.rdata(ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= pca_pkg::THRESHOLD_RST;
			step_q <= pca_pkg::STEP_RST;
			pix_q  <= pca_pkg::PIXELS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pca_pkg::CFG_THRESHOLD: thr_q  <= cfg_data;
				pca_pkg::CFG_STEP:      step_q <= cfg_data[pca_pkg::STEP_W-1:0];
				pca_pkg::CFG_PIXELS:    pix_q  <= cfg_data[pca_pkg::PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// item capture and result payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q <= kind;
			idx_q  <= pixel_index;
			val_q  <= pixel_value;
			last_q <= last_of_frame;
		end
		if (state_q == ST_READ) begin
			acc_q       <= ram_rdata;
			res_ph_q    <= '0;
			res_done_q  <= 1'b0;
			res_total_q <= '0;
			res_mean_q  <= '0;
			res_avg_q   <= '0;
		end
		if (state_q == ST_UPD) begin
			res_ph_q <= (ph > (pca_pkg::ACC_W+1)'(16'hFFFF)) ? '1 : ph[pca_pkg::PH_W-1:0];
			if (last_q) begin
				res_done_q  <= 1'b1;
				res_total_q <= tot_new;
			end
		end
		if ((state_q == ST_DIVM) && !div_busy) begin
			res_mean_q <= (div_num_q[DW-1:pca_pkg::MEAN_W] != '0) ? '1 :
				div_num_q[pca_pkg::MEAN_W-1:0];
		end
		if ((state_q == ST_DIVA) && !div_busy) begin
			res_avg_q <= div_num_q;
		end
		if ((state_q == ST_FIN) && (!out_valid || out_ready)) begin
			pixel_photons <= res_ph_q;
			frame_done    <= res_done_q;
			frame_total   <= res_total_q;
			frame_mean    <= res_mean_q;
			average_count <= res_avg_q;
		end
		// divider load or step
		if (state_q == ST_READ) begin
			div_rem_q <= '0;
			if (!kind_q) begin
				div_num_q <= ph_num;
				div_den_q <= pca_pkg::ACC_W'(step_eff);
			end else begin
				div_num_q <= {ram_rdata, 8'h00};
				div_den_q <= frames_q;
			end
		end else if ((state_q == ST_UPD) && last_q) begin
			div_rem_q <= '0;
			div_num_q <= {tot_new, 8'h00};
			div_den_q <= pca_pkg::ACC_W'(pix_eff);
		end else if (div_busy) begin
			div_num_q <= {div_num_q[DW-2:0], q_bit};
			div_rem_q <= q_bit ? rem_sh - {1'b0, div_den_q} : rem_sh;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			run_total_q <= '0;
			frames_q    <= '0;
			div_cnt_q   <= '0;
			out_valid   <= 1'b0;
		end else begin
			// the finish step refills the output slot itself
			if (out_valid && out_ready && (state_q != ST_FIN)) begin
				out_valid <= 1'b0;
			end
			if (div_busy) begin
				div_cnt_q <= div_cnt_q - CW'(1);
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(PIXELS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (!kind_q) begin
						div_cnt_q <= CW'(DW);
						state_q   <= ST_DIVP;
					end else if (in_range && (frames_q != '0)) begin
						div_cnt_q <= CW'(DW);
						state_q   <= ST_DIVA;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_DIVP: begin
					if (!div_busy) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (last_q) begin
						run_total_q <= '0;
						if (frames_q != '1) begin
							frames_q <= frames_q + pca_pkg::ACC_W'(1);
						end
						div_cnt_q <= CW'(DW);
						state_q   <= ST_DIVM;
					end else begin
						run_total_q <= tot_new;
						state_q     <= ST_FIN;
					end
				end
				ST_DIVM, ST_DIVA: begin
					if (!div_busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// wait for a free output slot
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ram writes only from the clearing pass or the update step
	`ASSERT_CLKD(a_ram_we_src, clk, arst_n, ram_we |-> (state_q == ST_CLEAR || state_q == ST_UPD))
	// an accepted item always goes to the ram read step
	`ASSERT_NEXT(a_xfer_read, clk, arst_n, in_xfer, state_q == ST_READ)
	// the divider is idle whenever a new item can be taken
	`ASSERT_CLKD(a_div_idle, clk, arst_n, in_ready |-> !div_busy)
endmodule
